>>> hdl/dacq_pkg.sv
// ----------------------------------------------------------------------------
// dacq_pkg
// shared types and constants for the directional ascent cost query block
// ----------------------------------------------------------------------------
package dacq_pkg;

   // fixed field widths of the channels
   localparam int CMD_BITS    = 2;
   localparam int HEIGHT_IN_BITS = 32;
   localparam int IDX_BITS    = 10;
   localparam int BUDGET_BITS = 48;
   localparam int STATUS_BITS = 2;
   localparam int REMAIN_BITS = 47;

   // parameter defaults
   localparam int DEPTH_DEFAULT       = 1024;
   localparam int HEIGHT_BITS_DEFAULT = 32;
   localparam int SUM_BITS_DEFAULT    = 48;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_APPEND  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_RESTART = 2'd2;

   // status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OVER  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic latch;
      logic restart;
      logic diff_en;
      logic write_en;
      logic read_en;
      logic cost_en;
      logic result_load;
   } dacq_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic full;
      logic out_busy;
   } dacq_stat_type;

endpackage

>>> hdl/dacq_if.sv
// ----------------------------------------------------------------------------
// dacq channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface dacq_req_if
   import dacq_pkg::*;
   ;
   logic                             valid;
   logic                             ready;
   logic [CMD_BITS-1:0]              cmd;
   logic signed [HEIGHT_IN_BITS-1:0] height;
   logic [IDX_BITS-1:0]              start_index;
   logic [IDX_BITS-1:0]              end_index;
   logic signed [BUDGET_BITS-1:0]    budget;

   modport source (output valid, cmd, height, start_index, end_index, budget,
                   input ready);
   modport sink   (input valid, cmd, height, start_index, end_index, budget,
                   output ready);
endinterface

interface dacq_rsp_if
   import dacq_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [REMAIN_BITS-1:0] remaining;

   modport source (output valid, status, remaining, input ready);
   modport sink   (input valid, status, remaining, output ready);
endinterface

>>> hdl/dacq_ctrl.sv
// ----------------------------------------------------------------------------
// dacq_ctrl
// command sequencer: accepts a beat and steps the datapath through it
// ----------------------------------------------------------------------------
module dacq_ctrl
   import dacq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CMD_BITS-1:0] req_cmd,
   output logic                req_ready,
   input  dacq_stat_type       stat,
   output dacq_ctrl_type       ctrl
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_COST   = 3'd4;
   localparam logic [2:0] S_RESULT = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.latch = 1'b1;
               unique case (req_cmd)
                  CMD_APPEND:  state_in = S_DIFF;
                  CMD_QUERY:   state_in = S_READ;
                  CMD_RESTART: ctrl.restart = 1'b1;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_DIFF: begin
            // a full store drops the append
            if (stat.full) begin
               state_in = S_IDLE;
            end else begin
               ctrl.diff_en = 1'b1;
               state_in     = S_WRITE;
            end
         end
         S_WRITE: begin
            ctrl.write_en = 1'b1;
            state_in      = S_IDLE;
         end
         S_READ: begin
            ctrl.read_en = 1'b1;
            state_in     = S_COST;
         end
         S_COST: begin
            ctrl.cost_en = 1'b1;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            if (!stat.out_busy) begin
               ctrl.result_load = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/dacq_datapath.sv
// ----------------------------------------------------------------------------
// dacq_datapath
// prefix store, append arithmetic, query cost and result register
// ----------------------------------------------------------------------------
module dacq_datapath
   import dacq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEFAULT,
   parameter int SUM_BITS    = SUM_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  dacq_ctrl_type                    ctrl,
   output dacq_stat_type                    stat,
   input  logic signed [HEIGHT_IN_BITS-1:0] req_height,
   input  logic [IDX_BITS-1:0]              req_start_index,
   input  logic [IDX_BITS-1:0]              req_end_index,
   input  logic signed [BUDGET_BITS-1:0]    req_budget,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [STATUS_BITS-1:0]           rsp_status,
   output logic [REMAIN_BITS-1:0]           rsp_remaining
);

   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CMP_BITS  = (CNT_BITS > IDX_BITS) ? CNT_BITS : IDX_BITS;
   localparam int AW_BITS   = (ADDR_BITS > IDX_BITS) ? ADDR_BITS : IDX_BITS;
   localparam int MAG_BITS  = HEIGHT_BITS + 1;
   localparam int DW_BITS   = (SUM_BITS > MAG_BITS) ? SUM_BITS : MAG_BITS;
   localparam int CW_BITS   = (SUM_BITS > BUDGET_BITS) ? SUM_BITS : BUDGET_BITS;

   // entry holds {rise, drop}
   logic [2*SUM_BITS-1:0] mem [DEPTH];

   // latched beat
   logic [HEIGHT_BITS-1:0]        height_ff;
   logic [IDX_BITS-1:0]           s_idx_ff;
   logic [IDX_BITS-1:0]           e_idx_ff;
   logic signed [BUDGET_BITS-1:0] budget_ff;

   // append state
   logic [CNT_BITS-1:0]    count_ff,  count_in;
   logic [HEIGHT_BITS-1:0] prev_ff,   prev_in;
   logic [SUM_BITS-1:0]    last_rise_ff, last_rise_in;
   logic [SUM_BITS-1:0]    last_drop_ff, last_drop_in;
   logic [MAG_BITS-1:0]    mag_ff,    mag_in;
   logic                   rising_ff, rising_in;

   // query state
   logic [2*SUM_BITS-1:0]  rd_s_ff;
   logic [2*SUM_BITS-1:0]  rd_e_ff;
   logic                   bad_ff, bad_in;
   logic                   fwd_ff, fwd_in;
   logic                   bad2_ff;
   logic [SUM_BITS-1:0]    cost_ff, cost_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [REMAIN_BITS-1:0] rsp_remaining_ff, rsp_remaining_in;

   logic signed [MAG_BITS-1:0] h_ext, p_ext, diff;
   logic [DW_BITS-1:0]         mag_wide;
   logic [SUM_BITS-1:0]        mag_sum, new_rise, new_drop;
   logic [ADDR_BITS-1:0]       waddr, s_addr, e_addr;
   logic [AW_BITS-1:0]         s_wide, e_wide;
   logic [CW_BITS-1:0]         cost_c, budget_c, left_c;
   logic                       over;

   assign stat.full     = (count_ff == CNT_BITS'(DEPTH));
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   // height step, sign-extended by one bit so it cannot overflow
   assign h_ext     = {height_ff[HEIGHT_BITS-1], height_ff};
   assign p_ext     = {prev_ff[HEIGHT_BITS-1], prev_ff};
   assign diff      = h_ext - p_ext;
   assign rising_in = !diff[HEIGHT_BITS] && (diff != '0);
   assign mag_in    = diff[HEIGHT_BITS] ? MAG_BITS'(-diff) : MAG_BITS'(diff);

   assign mag_wide = DW_BITS'(mag_ff);
   assign mag_sum  = mag_wide[SUM_BITS-1:0];

   always_comb begin
      if (count_ff == '0) begin
         new_rise = '0;
         new_drop = '0;
      end else begin
         new_rise = last_rise_ff + (rising_ff ? mag_sum : '0);
         new_drop = last_drop_ff + (rising_ff ? '0 : mag_sum);
      end
   end

   assign waddr  = count_ff[ADDR_BITS-1:0];
   assign s_wide = AW_BITS'(s_idx_ff);
   assign e_wide = AW_BITS'(e_idx_ff);
   assign s_addr = s_wide[ADDR_BITS-1:0];
   assign e_addr = e_wide[ADDR_BITS-1:0];

   assign bad_in = (CMP_BITS'(s_idx_ff) >= CMP_BITS'(count_ff)) ||
                   (CMP_BITS'(e_idx_ff) >= CMP_BITS'(count_ff));
   assign fwd_in = (s_idx_ff < e_idx_ff);

   assign cost_in = fwd_ff ? (rd_e_ff[2*SUM_BITS-1:SUM_BITS] - rd_s_ff[2*SUM_BITS-1:SUM_BITS])
                           : (rd_s_ff[SUM_BITS-1:0] - rd_e_ff[SUM_BITS-1:0]);

   // a negative budget is always exceeded
   assign cost_c   = CW_BITS'(cost_ff);
   assign budget_c = CW_BITS'(budget_ff[BUDGET_BITS-2:0]);
   assign over     = budget_ff[BUDGET_BITS-1] || (cost_c > budget_c);
   assign left_c   = budget_c - cost_c;

   always_comb begin
      count_in     = count_ff;
      prev_in      = prev_ff;
      last_rise_in = last_rise_ff;
      last_drop_in = last_drop_ff;
      if (ctrl.restart) begin
         count_in = '0;
      end else if (ctrl.write_en) begin
         count_in     = count_ff + 1'b1;
         prev_in      = height_ff;
         last_rise_in = new_rise;
         last_drop_in = new_drop;
      end
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_status_in    = rsp_status_ff;
      rsp_remaining_in = rsp_remaining_ff;
      if (ctrl.result_load) begin
         rsp_valid_in = 1'b1;
         if (bad2_ff) begin
            rsp_status_in    = STATUS_RANGE;
            rsp_remaining_in = '0;
         end else if (over) begin
            rsp_status_in    = STATUS_OVER;
            rsp_remaining_in = '0;
         end else begin
            rsp_status_in    = STATUS_OK;
            rsp_remaining_in = left_c[REMAIN_BITS-1:0];
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_rise_ff     <= last_rise_in;
      last_drop_ff     <= last_drop_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_remaining_ff <= rsp_remaining_in;
      if (ctrl.latch) begin
         height_ff <= req_height[HEIGHT_BITS-1:0];
         s_idx_ff  <= req_start_index;
         e_idx_ff  <= req_end_index;
         budget_ff <= req_budget;
      end
      if (ctrl.diff_en) begin
         mag_ff    <= mag_in;
         rising_ff <= rising_in;
      end
      if (ctrl.read_en) begin
         bad_ff <= bad_in;
         fwd_ff <= fwd_in;
      end
      if (ctrl.cost_en) begin
         cost_ff <= cost_in;
         bad2_ff <= bad_ff;
      end
   end

   // prefix store
   always_ff @(posedge clock) begin
      if (ctrl.write_en) begin
         mem[waddr] <= {new_rise, new_drop};
      end
      if (ctrl.read_en) begin
         rd_s_ff <= mem[s_addr];
         rd_e_ff <= mem[e_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_remaining = rsp_remaining_ff;

endmodule

>>> hdl/directional_ascent_cost_query.sv
// ----------------------------------------------------------------------------
// directional_ascent_cost_query
// heights are appended into a prefix store of rise and drop totals; a query
// returns budget minus the ascent cost of a walk between two indices
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake       payload
//   req_ch    in          valid / ready   cmd, height, start_index, end_index, budget
//   rsp_ch    out         valid / ready   status, remaining
//
// one beat is worked at a time; ready is high only in the idle state
// append steps through accept, height step, and add and store write; with a full
// store it ends in the height step; restart and unused commands end on accept; a
// query steps through accept, store read, cost subtract and budget compare, plus
// any wait for the response register to empty
// the prefix store has one write port and two read ports; it is not cleared
// reset is synchronous and clears the count, the last height and rsp valid
// while a response waits, appends and restarts still flow; a new query
// holds in its last step until the response beat is taken
// ----------------------------------------------------------------------------
module directional_ascent_cost_query
   import dacq_pkg::*;
#(
   parameter int DEPTH       = DEPTH_DEFAULT,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEFAULT,
   parameter int SUM_BITS    = SUM_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dacq_req_if.sink   req_ch,
   dacq_rsp_if.source rsp_ch
);

   // command and status between sequencer and datapath
   dacq_ctrl_type ctrl;
   dacq_stat_type stat;

   // sequencer: owns req ready and the per-command step order
   dacq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // datapath: prefix store, arithmetic and the response register
   dacq_datapath #(
      .DEPTH       (DEPTH),
      .HEIGHT_BITS (HEIGHT_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_height      (req_ch.height),
      .req_start_index (req_ch.start_index),
      .req_end_index   (req_ch.end_index),
      .req_budget      (req_ch.budget),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_remaining   (rsp_ch.remaining)
   );

endmodule
